@@ sv/word_mul_div_rem_unit_defines.svh @@
// assertion macros for the word multiply divide unit
`ifndef WORD_MUL_DIV_REM_UNIT_DEFINES_SVH
`define WORD_MUL_DIV_REM_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define WMDR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("label");
`define WMDR_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("label");
`else
`define WMDR_ASSERT(label, clk, rst_n, prop)
`define WMDR_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ sv/wmdr_pkg.sv @@
// shared types and constants for the word multiply divide unit
`default_nettype none
package wmdr_pkg;
  localparam int unsigned XLEN = 64;
  localparam int unsigned WLEN = 32;
  localparam int unsigned REG_W = 5;
  localparam int unsigned OP_W = 3;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES = WLEN / BITS_PER_STAGE;
  localparam int unsigned IN_DATA_W = 136;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [OP_W-1:0] {
    OP_MULW  = 3'd0,
    OP_DIVW  = 3'd1,
    OP_DIVUW = 3'd2,
    OP_REMW  = 3'd3,
    OP_REMUW = 3'd4
  } op_t;

  typedef struct packed {
    logic             is_mul;
    logic             is_rem;
    logic             is_bad;
    logic             b_zero;
    logic             neg_q;
    logic             neg_r;
    logic [WLEN-1:0]  a_low;
    logic [REG_W-1:0] dest;
  } ctl_t;
endpackage
`default_nettype wire

@@ sv/word_mul_div_rem_unit.sv @@
// top level: pipelined rv64m word multiply, divide and remainder
//   channel | dir | fields (tdata lsb first)
//   in_     | in  | operand_a[63:0] operand_b[127:64] dest_index[132:128]; tuser req_type
//   out_    | out | result_value[63:0] result_dest[68:64]
// one transaction enters per cycle unless out_ stalls; results are registered
// the divide is a chain of radix-4 restoring stages, two quotient bits per stage
// multiply shares the pipe: 32x32 product in the first stage, then travels along
// a stall at the output holds every stage; valid bits clear on reset
`default_nettype none
`include "word_mul_div_rem_unit_defines.svh"
module word_mul_div_rem_unit #(
  parameter int unsigned STAGES = wmdr_pkg::DIV_STAGES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // operand_a, operand_b, dest_index, zero fill
  input  wire logic [wmdr_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type
  input  wire logic [wmdr_pkg::OP_W-1:0]        in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // result_value, result_dest, zero fill
  output logic [wmdr_pkg::OUT_DATA_W-1:0]       out_tdata
);
  import wmdr_pkg::*;

  localparam int unsigned BPS = WLEN / STAGES;

  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  logic [WLEN-1:0] a_in, b_in;
  logic [OP_W-1:0] op_in;
  logic sgn_in;
  assign a_in = in_tdata[WLEN-1:0];
  assign b_in = in_tdata[XLEN+WLEN-1:XLEN];
  assign op_in = in_tuser;
  assign sgn_in = (op_in == OP_DIVW) || (op_in == OP_REMW);

  // stage 0: decode, magnitudes, multiply
  logic            v0_r;
  ctl_t            c0_r, c0_nxt;
  logic [WLEN-1:0] ma_r, mb_r, ma_nxt, mb_nxt;
  logic [WLEN-1:0] prod_r, prod_nxt;

  always_comb begin
    c0_nxt.is_mul = (op_in == OP_MULW);
    c0_nxt.is_rem = (op_in == OP_REMW) || (op_in == OP_REMUW);
    c0_nxt.is_bad = !((op_in == OP_MULW) || (op_in == OP_DIVW) || (op_in == OP_DIVUW) ||
                      (op_in == OP_REMW) || (op_in == OP_REMUW));
    c0_nxt.b_zero = (b_in == '0);
    c0_nxt.neg_q  = sgn_in && (a_in[WLEN-1] ^ b_in[WLEN-1]);
    c0_nxt.neg_r  = sgn_in && a_in[WLEN-1];
    c0_nxt.a_low  = a_in;
    c0_nxt.dest   = in_tdata[2*XLEN+REG_W-1:2*XLEN];
    ma_nxt = (sgn_in && a_in[WLEN-1]) ? (~a_in + 1'b1) : a_in;
    mb_nxt = (sgn_in && b_in[WLEN-1]) ? (~b_in + 1'b1) : b_in;
    prod_nxt = a_in * b_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_tvalid;
    end
    if (adv) begin
      c0_r <= c0_nxt;
      ma_r <= ma_nxt;
      mb_r <= mb_nxt;
      prod_r <= prod_nxt;
    end
  end

  // divide stages
  logic [STAGES:0]           v_r;
  ctl_t                      c_r   [STAGES+1];
  logic [WLEN-1:0]           q_r   [STAGES+1];
  logic [WLEN-1:0]           rm_r  [STAGES+1];
  logic [WLEN-1:0]           d_r   [STAGES+1];
  logic [WLEN-1:0]           p_r   [STAGES+1];

  assign v_r[0] = v0_r;
  assign c_r[0] = c0_r;
  assign q_r[0] = ma_r;
  assign rm_r[0] = '0;
  assign d_r[0] = mb_r;
  assign p_r[0] = prod_r;

  for (genvar s = 0; s < STAGES; s++) begin : g_div
    logic [WLEN-1:0] q_nxt, rm_nxt;
    logic            v_q;
    always_comb begin
      logic [WLEN:0] t;
      q_nxt = q_r[s];
      rm_nxt = rm_r[s];
      for (int k = 0; k < BPS; k++) begin
        t = {rm_nxt, q_nxt[WLEN-1]} - {1'b0, d_r[s]};
        q_nxt = {q_nxt[WLEN-2:0], !t[WLEN]};
        rm_nxt = t[WLEN] ? {rm_nxt[WLEN-2:0], q_r[s][WLEN-1-k]} : t[WLEN-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_q <= 1'b0;
      end else if (adv) begin
        v_q <= v_r[s];
      end
    end
    ctl_t            c_q;
    logic [WLEN-1:0] q_q, rm_q, d_q, p_q;
    always_ff @(posedge clk) begin
      if (adv) begin
        c_q <= c_r[s];
        q_q <= q_nxt;
        rm_q <= rm_nxt;
        d_q <= d_r[s];
        p_q <= p_r[s];
      end
    end
    assign v_r[s+1] = v_q;
    assign c_r[s+1] = c_q;
    assign q_r[s+1] = q_q;
    assign rm_r[s+1] = rm_q;
    assign d_r[s+1] = d_q;
    assign p_r[s+1] = p_q;
  end

  // final stage: sign fix, special cases, sign extension
  logic            vf_r;
  logic [XLEN-1:0] res_r, res_nxt;
  logic [REG_W-1:0] dst_r;
  ctl_t            cf;
  logic [WLEN-1:0] qf, rf, w;

  always_comb begin
    cf = c_r[STAGES];
    qf = cf.neg_q ? (~q_r[STAGES] + 1'b1) : q_r[STAGES];
    rf = cf.neg_r ? (~rm_r[STAGES] + 1'b1) : rm_r[STAGES];
    if (cf.is_mul) begin
      w = p_r[STAGES];
    end else if (cf.is_rem) begin
      w = cf.b_zero ? cf.a_low : rf;
    end else begin
      w = cf.b_zero ? '1 : qf;
    end
    res_nxt = cf.is_bad ? '0 : {{(XLEN-WLEN){w[WLEN-1]}}, w};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (adv) begin
      vf_r <= v_r[STAGES];
    end
    if (adv) begin
      res_r <= res_nxt;
      dst_r <= cf.dest;
    end
  end

  assign out_tvalid = vf_r;
  assign out_tdata = {{(OUT_DATA_W-XLEN-REG_W){1'b0}}, dst_r, res_r};

  `WMDR_ASSERT(a_hold, clk, rst_n, (out_tvalid && !out_tready) |=> $stable(out_tdata))
  `WMDR_ASSERT(a_ready, clk, rst_n, in_tready == (!out_tvalid || out_tready))
  `WMDR_ASSERT(a_flow, clk, rst_n, (adv && v_r[STAGES]) |=> out_tvalid)
  `WMDR_ASSERT_RST(a_rst, clk, !rst_n |=> !out_tvalid)
endmodule
`default_nettype wire

@@ tb/wmdr_checker.sv @@
// checker module: watches both channels, predicts word results and compares them
`timescale 1ns / 1ps
module wmdr_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [wmdr_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [wmdr_pkg::OP_W-1:0]      in_tuser,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [wmdr_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                                  fail_count,
  output int                                  pending_count,
  output int                                  result_count
);
  import wmdr_pkg::*;

  typedef struct {
    logic [63:0] value;
    logic [4:0]  dest;
  } wb_t;

  wb_t wb_queue[$];

  function automatic logic [63:0] sext_word(logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

  function automatic logic [63:0] word_result(logic [2:0] op, logic [63:0] a, logic [63:0] b);
    logic [31:0] ua;
    logic [31:0] ub;
    logic [63:0] prod;
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    ua = a[31:0];
    ub = b[31:0];
    sa = a[31:0];
    sb = b[31:0];
    case (op)
      OP_MULW: begin
        prod = ua * ub;
        return sext_word(prod[31:0]);
      end
      OP_DIVW: begin
        if (ub == 0) return '1;
        if (ua == 32'h8000_0000 && ub == 32'hffff_ffff) return sext_word(32'h8000_0000);
        return sext_word(sa / sb);
      end
      OP_DIVUW: begin
        if (ub == 0) return '1;
        return sext_word(ua / ub);
      end
      OP_REMW: begin
        if (ub == 0) return sext_word(ua);
        if (ua == 32'h8000_0000 && ub == 32'hffff_ffff) return '0;
        return sext_word(sa % sb);
      end
      OP_REMUW: begin
        if (ub == 0) return sext_word(ua);
        return sext_word(ua % ub);
      end
      default: return '0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] exp_v);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    wb_t e;
    if (rst_n && in_tvalid && in_tready) begin
      e.value = word_result(in_tuser, in_tdata[63:0], in_tdata[127:64]);
      e.dest = in_tdata[132:128];
      wb_queue.push_back(e);
    end
    if (rst_n && out_tvalid && out_tready) begin
      result_count++;
      if (wb_queue.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[63:0], '0);
      end else begin
        e = wb_queue.pop_front();
        if (out_tdata[63:0] !== e.value) report_mismatch("result_value", out_tdata[63:0], e.value);
        if (out_tdata[68:64] !== e.dest) report_mismatch("result_dest", out_tdata[68:64], e.dest);
      end
    end
    pending_count = wb_queue.size();
  end
endmodule

@@ tb/tb_word_mul_div_rem_unit.sv @@
// testbench top: drives word multiply divide requests and gives the verdict
`timescale 1ns / 1ps
module tb_word_mul_div_rem_unit;
  import wmdr_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int fail_count;
  int pending_count;
  int result_count;
  int send_idle_pct = 37;
  int recv_idle_pct = 88;
  int req_count = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  word_mul_div_rem_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  wmdr_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  always @(posedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(7))
      0: return 64'h0;
      1: return {$urandom, 32'h8000_0000};
      2: return {$urandom, 32'hffff_ffff};
      3: return {$urandom, 32'h0000_0000};
      4: return {$urandom, 28'h0, 4'($urandom)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_req(input logic [2:0] op, input logic [63:0] a, input logic [63:0] b,
                          input logic [4:0] dest);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {3'b0, dest, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    req_count++;
  endtask

  task automatic run_phase(input int n);
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_req(op, pick_operand(), pick_operand(), 5'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed corners
    for (int op = 0; op < 8; op++) begin
      send_req(op[2:0], 64'hffff_ffff_8000_0000, 64'h0000_0000_ffff_ffff, 5'd31);
      send_req(op[2:0], 64'h1234_5678_7fff_ffff, 64'hffff_ffff_0000_0000, 5'd0);
    end
    send_req(OP_MULW, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd1);
    send_req(OP_MULW, 64'h0, 64'h0, 5'd2);
    send_req(OP_DIVUW, 64'hffff_ffff, 64'h1, 5'd3);
    send_req(OP_REMUW, 64'hffff_ffff, 64'h7, 5'd4);
    send_req(OP_DIVW, 64'hffff_fff9, 64'h2, 5'd5);
    send_req(OP_REMW, 64'hffff_fff9, 64'h2, 5'd6);
    send_req(OP_DIVW, 64'h7, 64'hffff_fffe, 5'd7);
    run_phase(560);
    send_idle_pct = 88;
    recv_idle_pct = 37;
    run_phase(560);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(610);
    in_tvalid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (DIV_STAGES + 10) @(posedge clk);
    $display("covered %0d requests, all ops incl. unused codes, zero divisors and overflow",
             req_count);
    $display("checked %0d results under three idle patterns", result_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+sv
sv/wmdr_pkg.sv
sv/word_mul_div_rem_unit.sv
tb/wmdr_checker.sv
tb/tb_word_mul_div_rem_unit.sv
